### rtl/pid_controller_filtered_derivative_assert.svh
// Assertion macros of the PID controller RTL.
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_ASSERT_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on clk, switched off while rst_n is low.
`define PIDFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Checked on clk at every edge, reset included.
`define PIDFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define PIDFD_ASSERT(lbl, prop, msg)
`define PIDFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/pidfd_pkg.sv
// Types, constants and fixed-point helpers of the PID controller.
package pidfd_pkg;

    // Build options
    localparam bit ANTI_WINDUP_ON  = 1'b1;
    localparam bit DERIV_FILTER_ON = 1'b1;

    // 0.1 in Q0.16
    localparam logic signed [15:0] TENTH_Q16 = 16'sd6554;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        IDX_PROP_GAIN,
        IDX_INTEGRAL_GAIN,
        IDX_DERIVATIVE_GAIN,
        IDX_DERIVATIVE_POLE,
        IDX_OUT_MIN,
        IDX_OUT_MAX,
        IDX_INT_MIN,
        IDX_INT_MAX
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integral_gain;
        logic signed [31:0] derivative_gain;
        logic signed [25:0] derivative_pole;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
        logic signed [31:0] int_min;
        logic signed [31:0] int_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:       32'sd0,
        integral_gain:   32'sd0,
        derivative_gain: 32'sd0,
        derivative_pole: 26'sd0,
        out_min:         S32_MIN,
        out_max:         S32_MAX,
        int_min:         S32_MIN,
        int_max:         S32_MAX
    };

    // Differences of one sample
    typedef struct packed {
        logic signed [31:0] error;
        logic signed [31:0] esum;
        logic signed [31:0] derr;
        logic signed [31:0] dsens;
    } diff_t;

    // Products after the first multiply stage
    typedef struct packed {
        logic signed [31:0] error;
        logic signed [31:0] p_term;
        logic signed [31:0] i_step;
        logic signed [31:0] d_part;
        logic signed [31:0] aw_base;
    } prod_t;

    // Everything the feedback stage needs
    typedef struct packed {
        logic signed [31:0] error;
        logic signed [31:0] p_term;
        logic signed [31:0] i_step;
        logic signed [31:0] d_part;
        logic signed [31:0] aw_step;
    } loop_t;

    // Saturate a 33-bit sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? S32_MIN : S32_MAX;
        else
            r = $signed(v[31:0]);
        return r;
    endfunction

    // Round half up at bit sh, then saturate to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic signed [63:0] r;
        logic signed [31:0] q;
        r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (r > 64'(S32_MAX))
            q = S32_MAX;
        else if (r < 64'(S32_MIN))
            q = S32_MIN;
        else
            q = $signed(r[31:0]);
        return q;
    endfunction

endpackage

### rtl/pidfd_cfg.sv
// Configuration register file of the PID controller.
module pidfd_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pidfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pidfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output pidfd_pkg::cfg_t                   cfg
);
    import pidfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                IDX_PROP_GAIN:       cfg_next.prop_gain       = $signed(cfg_wdata);
                IDX_INTEGRAL_GAIN:   cfg_next.integral_gain   = $signed(cfg_wdata);
                IDX_DERIVATIVE_GAIN: cfg_next.derivative_gain = $signed(cfg_wdata);
                IDX_DERIVATIVE_POLE: cfg_next.derivative_pole = $signed(cfg_wdata[25:0]);
                IDX_OUT_MIN:         cfg_next.out_min         = $signed(cfg_wdata);
                IDX_OUT_MAX:         cfg_next.out_max         = $signed(cfg_wdata);
                IDX_INT_MIN:         cfg_next.int_min         = $signed(cfg_wdata);
                IDX_INT_MAX:         cfg_next.int_max         = $signed(cfg_wdata);
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pidfd_diff.sv
// Input register and difference stage: error, error sum and differences.
module pidfd_diff (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  target,
    input  logic signed [31:0]  sensed,
    output logic                out_valid,
    input  logic                out_ready,
    output pidfd_pkg::diff_t    out_word
);
    import pidfd_pkg::*;

    // Stage 0: input register
    logic               v0_reg;
    logic signed [31:0] tgt_reg;
    logic signed [31:0] sns_reg;
    // Stage 1: differences
    logic               v1_reg;
    diff_t              d_reg;
    diff_t              d_next;
    // Previous sample
    logic signed [31:0] last_err_reg;
    logic signed [31:0] last_sns_reg;

    logic ready0;
    logic ready1;
    logic load0;
    logic load1;

    assign ready1 = !v1_reg || out_ready;
    assign ready0 = !v0_reg || ready1;
    assign load0  = in_valid && ready0;
    assign load1  = v0_reg && ready1;

    // Saturating differences
    always_comb
    begin
        d_next.error = sat33({tgt_reg[31], tgt_reg} - {sns_reg[31], sns_reg});
        d_next.esum  = sat33({d_next.error[31], d_next.error}
                             + {last_err_reg[31], last_err_reg});
        d_next.derr  = sat33({d_next.error[31], d_next.error}
                             - {last_err_reg[31], last_err_reg});
        d_next.dsens = sat33({sns_reg[31], sns_reg} - {last_sns_reg[31], last_sns_reg});
    end

    // Valid bits and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            last_err_reg <= '0;
            last_sns_reg <= '0;
        end
        else
        begin
            v0_reg <= load0 || (v0_reg && !ready1);
            v1_reg <= load1 || (v1_reg && !out_ready);
            if (load1)
            begin
                last_err_reg <= d_next.error;
                last_sns_reg <= sns_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            tgt_reg <= target;
            sns_reg <= sensed;
        end
        if (load1)
            d_reg <= d_next;
    end

    assign in_ready  = ready0;
    assign out_valid = v1_reg;
    assign out_word  = d_reg;

endmodule

### rtl/pidfd_prod.sv
// Two multiply stages: gain products, then the anti-windup tenth.
module pidfd_prod (
    input  logic                clk,
    input  logic                rst_n,
    input  pidfd_pkg::cfg_t     cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  pidfd_pkg::diff_t    in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output pidfd_pkg::loop_t    out_word
);
    import pidfd_pkg::*;

    logic  va_reg;
    prod_t pa_reg;
    prod_t pa_next;
    logic  vb_reg;
    loop_t pb_reg;
    loop_t pb_next;

    logic signed [63:0] p_prod;
    logic signed [63:0] i_prod;
    logic signed [63:0] t_prod;
    logic signed [63:0] d_prod;
    logic signed [63:0] aw_prod;

    logic readya;
    logic readyb;
    logic loada;
    logic loadb;

    assign readyb = !vb_reg || out_ready;
    assign readya = !va_reg || readyb;
    assign loada  = in_valid && readya;
    assign loadb  = va_reg && readyb;

    // Stage A: coefficient products
    always_comb
    begin
        p_prod = 64'(cfg.prop_gain) * 64'(in_word.error);
        i_prod = 64'(cfg.integral_gain) * 64'(in_word.esum);
        t_prod = 64'(cfg.integral_gain) * 64'(in_word.error);
        if (DERIV_FILTER_ON)
            d_prod = -(64'(cfg.derivative_gain) * 64'(in_word.dsens));
        else
            d_prod = 64'(cfg.derivative_gain) * 64'(in_word.derr);
        pa_next.error   = in_word.error;
        pa_next.p_term  = round_sat(p_prod, 24);
        pa_next.i_step  = round_sat(i_prod, 25);
        pa_next.d_part  = round_sat(d_prod, 24);
        pa_next.aw_base = round_sat(t_prod, 24);
    end

    // Stage B: anti-windup step is a tenth of ki*error
    always_comb
    begin
        aw_prod         = 64'(pa_reg.aw_base) * 64'(TENTH_Q16);
        pb_next.error   = pa_reg.error;
        pb_next.p_term  = pa_reg.p_term;
        pb_next.i_step  = pa_reg.i_step;
        pb_next.d_part  = pa_reg.d_part;
        pb_next.aw_step = round_sat(aw_prod, 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= loada || (va_reg && !readyb);
            vb_reg <= loadb || (vb_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (loada)
            pa_reg <= pa_next;
        if (loadb)
            pb_reg <= pb_next;
    end

    assign in_ready  = readya;
    assign out_valid = vb_reg;
    assign out_word  = pb_reg;

endmodule

### rtl/pidfd_loop.sv
// Feedback stage: integrator, derivative filter, output clamp, anti-windup.
module pidfd_loop (
    input  logic                clk,
    input  logic                rst_n,
    input  pidfd_pkg::cfg_t     cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  pidfd_pkg::loop_t    in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  drive,
    output logic                clipped
);
    import pidfd_pkg::*;

    logic               v_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;
    logic signed [31:0] last_deriv_reg;
    logic signed [31:0] deriv_next;
    logic signed [31:0] drive_reg;
    logic signed [31:0] drive_next;
    logic               clip_reg;
    logic               clip_next;

    logic signed [31:0] integ;
    logic signed [31:0] integ_sum;
    logic signed [63:0] pole_prod;
    logic signed [31:0] pole_term;
    logic signed [31:0] pi_sum;
    logic signed [31:0] total;
    logic               same_sign;
    logic               load;

    assign in_ready = !v_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        // Trapezoidal integrator, clamped (max test first)
        integ_sum = sat33({acc_reg[31], acc_reg} + {in_word.i_step[31], in_word.i_step});
        if (integ_sum > cfg.int_max)
            integ = cfg.int_max;
        else if (integ_sum < cfg.int_min)
            integ = cfg.int_min;
        else
            integ = integ_sum;

        // Derivative: filter feedback from the previous derivative
        pole_prod = 64'(cfg.derivative_pole) * 64'(last_deriv_reg);
        pole_term = round_sat(pole_prod, 24);
        if (DERIV_FILTER_ON)
            deriv_next = sat33({in_word.d_part[31], in_word.d_part}
                               + {pole_term[31], pole_term});
        else
            deriv_next = in_word.d_part;

        // P + I + D, clamped to the output range
        pi_sum = sat33({in_word.p_term[31], in_word.p_term} + {integ[31], integ});
        total  = sat33({pi_sum[31], pi_sum} + {deriv_next[31], deriv_next});
        if (total > cfg.out_max)
        begin
            drive_next = cfg.out_max;
            clip_next  = 1'b1;
        end
        else if (total < cfg.out_min)
        begin
            drive_next = cfg.out_min;
            clip_next  = 1'b1;
        end
        else
        begin
            drive_next = total;
            clip_next  = 1'b0;
        end

        // Anti-windup: back off when clipped and pushing the same way
        same_sign = (in_word.error > 32'sd0 && integ > 32'sd0)
                 || (in_word.error < 32'sd0 && integ < 32'sd0);
        if (ANTI_WINDUP_ON && clip_next && same_sign)
            acc_next = sat33({integ[31], integ} - {in_word.aw_step[31], in_word.aw_step});
        else
            acc_next = integ;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= 1'b0;
            acc_reg        <= '0;
            last_deriv_reg <= '0;
        end
        else
        begin
            v_reg <= load || (v_reg && !out_ready);
            if (load)
            begin
                acc_reg        <= acc_next;
                last_deriv_reg <= deriv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
            clip_reg  <= clip_next;
        end
    end

    assign out_valid = v_reg;
    assign drive     = drive_reg;
    assign clipped   = clip_reg;

`include "pid_controller_filtered_derivative_assert.svh"

    // Loop state moves only with a new sample
    `PIDFD_ASSERT(a_state_hold, !load |=> $stable(acc_reg) && $stable(last_deriv_reg), "loop state changed without a sample")
    // A result appears only after a sample was taken
    `PIDFD_ASSERT(a_valid_from_load, $rose(out_valid) |-> $past(load), "result valid without a sample")
    // With nothing new coming, a taken result empties the stage
    `PIDFD_ASSERT(a_drain, out_valid && out_ready && !in_valid |=> !out_valid, "result stage did not drain")

endmodule

### rtl/pid_controller_filtered_derivative.sv
// Top level of the PID controller with filtered derivative and anti-windup.
// One sample word per clock: each accepted (target, sensed) word gives one
// (drive, clipped) word, with a new word taken every cycle
// while the output side keeps up; a stalled output stops the pipeline only
// as far back as there are full stages. Two stages register the input and
// form saturated differences, two stages do the gain multiplies and the
// anti-windup tenth, and the last
// stage closes the loop: integrator add and clamp, the derivative-pole
// multiply on the previous derivative, the output clamp and the anti-windup
// correction all sit there, and that path sets the clock. Values are Q16.16,
// coefficients Q8.24 (derivative pole Q2.24), and every sum saturates to 32 bits.
// The user writes configuration registers through cfg_wr_en/cfg_addr/cfg_wdata
// only while no sample is in flight; the block itself does not enforce it.
module pid_controller_filtered_derivative (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [pidfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pidfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Sample input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,   // [31:0] target, [63:32] sensed
    // Controller output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [31:0] drive
    output logic [0:0]                        m_axis_tuser    // [0] clipped
);
    import pidfd_pkg::*;

    cfg_t  cfg;
    diff_t diff_word;
    loop_t loop_word;
    logic  diff_valid;
    logic  diff_ready;
    logic  loop_valid;
    logic  loop_ready;
    logic signed [31:0] drive;
    logic  clipped;

    pidfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidfd_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .target    ($signed(s_axis_tdata[31:0])),
        .sensed    ($signed(s_axis_tdata[63:32])),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .out_word  (diff_word)
    );

    pidfd_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .in_word   (diff_word),
        .out_valid (loop_valid),
        .out_ready (loop_ready),
        .out_word  (loop_word)
    );

    pidfd_loop u_loop (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (loop_valid),
        .in_ready  (loop_ready),
        .in_word   (loop_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .drive     (drive),
        .clipped   (clipped)
    );

    assign m_axis_tdata    = drive;
    assign m_axis_tuser[0] = clipped;

endmodule
